@@ rtl/assert_macros.svh @@
// assertion helpers, sampled on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

@@ rtl/bsoc_pkg.sv @@
`timescale 1ns / 1ps
package bsoc_pkg;

  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = ADDR_W + 1;
  localparam int DATA_W   = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_COPY  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_COPY,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              ok;
    logic [LEN_W-1:0]  fill_count;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] source;
    logic [LEN_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

@@ rtl/bsoc_ram.sv @@
`timescale 1ns / 1ps
module bsoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bsoc_fifo.sv @@
`timescale 1ns / 1ps
module bsoc_fifo
  import bsoc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] used;

  assign head         = entries[rd_ptr];
  assign status.full  = (used == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (used == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_entry;
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        used <= used + 1'b1;
      end else if (pop && !push) begin
        used <= used - 1'b1;
      end
    end
  end

endmodule

@@ rtl/bsoc_front.sv @@
`timescale 1ns / 1ps
module bsoc_front
  import bsoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [ADDR_W-1:0] target,
  input  logic [ADDR_W-1:0] source,
  input  logic [LEN_W-1:0]  count,
  input  logic [DATA_W-1:0] value,
  input  back_status_t      back_status,
  input  q_status_t         q_status,
  output logic              push,
  output q_entry_t          push_entry
);

  localparam logic [LEN_W:0] CAP_EXT = (LEN_W + 1)'(CAPACITY);

  logic [LEN_W-1:0] fill_length;
  logic [LEN_W-1:0] fill_length_next;
  logic [LEN_W-1:0] tgt_end;
  logic [LEN_W:0]   need;
  logic [LEN_W:0]   src_end;
  logic [LEN_W:0]   fill_ext;
  cmd_kind_t        kind;
  logic             ok;

  assign in_ready = !back_status.clearing && !q_status.full;
  assign push     = in_valid && in_ready;

  assign tgt_end  = LEN_W'(target) + 1'b1;
  assign need     = (LEN_W + 1)'(target) + (LEN_W + 1)'(count);
  assign src_end  = (LEN_W + 1)'(source) + (LEN_W + 1)'(count);
  assign fill_ext = (LEN_W + 1)'(fill_length);

  always_comb begin
    kind = CMD_NONE;
    ok = 1'b0;
    fill_length_next = fill_length;
    case (op)
      OP_WRITE: begin
        kind = CMD_WRITE;
        ok = 1'b1;
        if (tgt_end > fill_length) begin
          fill_length_next = tgt_end;
        end
      end
      OP_COPY: begin
        if (count == '0) begin
          ok = 1'b1;
        end else if (LEN_W'(source) >= fill_length) begin
          ok = 1'b0;
        end else if (target <= source && src_end > fill_ext) begin
          ok = 1'b0;
        end else if (need > CAP_EXT) begin
          ok = 1'b0;
        end else begin
          kind = CMD_COPY;
          ok = 1'b1;
          if (need > fill_ext) begin
            fill_length_next = LEN_W'(need);
          end
        end
      end
      OP_READ: begin
        if (LEN_W'(target) < fill_length) begin
          kind = CMD_READ;
          ok = 1'b1;
        end
      end
      default: begin
        kind = CMD_NONE;
      end
    endcase
  end

  always_comb begin
    push_entry.kind       = kind;
    push_entry.ok         = ok;
    push_entry.fill_count = fill_length_next;
    push_entry.target     = target;
    push_entry.source     = source;
    push_entry.count      = count;
    push_entry.value      = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_length <= '0;
    end else if (push) begin
      fill_length <= fill_length_next;
    end
  end

endmodule

@@ rtl/bsoc_back.sv @@
`timescale 1ns / 1ps
module bsoc_back
  import bsoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  q_entry_t          head,
  input  q_status_t         q_status,
  output logic              pop,
  output back_status_t      back_status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [LEN_W-1:0]  fill_count,
  output logic [DATA_W-1:0] read_byte
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_COPY
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  remaining;
  logic [LEN_W-1:0]  cur_fill;
  logic              bypass;
  logic [DATA_W-1:0] bypass_data;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] copy_byte;
  logic              slot_free;

  bsoc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_free = !out_valid || out_ready;
  // a byte written in the same cycle it is read comes from the bypass
  assign copy_byte = bypass ? bypass_data : ram_rdata;

  assign back_status.clearing = (state == S_CLEAR);

  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = copy_byte;
    ram_raddr = rd_addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_raddr = (head.kind == CMD_READ) ? head.target : head.source;
        if (!q_status.empty && slot_free) begin
          pop = 1'b1;
          if (head.kind == CMD_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = head.target;
            ram_wdata = head.value;
          end
        end
      end
      S_READ: begin
        ram_we = 1'b0;
      end
      S_COPY: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      bypass    <= 1'b0;
    end else begin
      bypass      <= ram_we && (ram_raddr == ram_waddr);
      bypass_data <= ram_wdata;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            case (head.kind)
              CMD_READ: begin
                state    <= S_READ;
                cur_fill <= head.fill_count;
              end
              CMD_COPY: begin
                state     <= S_COPY;
                rd_addr   <= head.source + 1'b1;
                wr_addr   <= head.target;
                remaining <= head.count;
                cur_fill  <= head.fill_count;
              end
              default: begin
                out_valid  <= 1'b1;
                ok         <= head.ok;
                fill_count <= head.fill_count;
                read_byte  <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid  <= 1'b1;
          ok         <= 1'b1;
          fill_count <= cur_fill;
          read_byte  <= ram_rdata;
          state      <= S_IDLE;
        end
        S_COPY: begin
          rd_addr   <= rd_addr + 1'b1;
          wr_addr   <= wr_addr + 1'b1;
          remaining <= remaining - 1'b1;
          if (remaining == LEN_W'(1)) begin
            out_valid  <= 1'b1;
            ok         <= 1'b1;
            fill_count <= cur_fill;
            read_byte  <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/byte_store_with_overlap_copy_core.sv @@
// byte store with fill length and forward, overlap-aware copy
// input channel (in_valid/in_ready): op, target, source, count, value;
//   op selects write byte, copy within store or read byte
// output channel (out_valid/out_ready): ok, fill_count, read_byte, one
//   result transaction for every input transaction, in order
// path from input transaction to result: the queue entry, then the result
//   register for a write, a rejected op or a zero-length copy; a read adds
//   the S_READ state before it, a copy the S_COPY state for its bytes
// throughput: one write per cycle while the result register is not stalled;
//   a read or a copy holds the sequencer until it ends; the single port pair
//   of the 4096 x 8 store memory sets this, a copy moving one byte per cycle
// a two-entry queue between the classifier and the memory sequencer lets
//   new transactions be taken while a copy runs or a result waits
// reset: after rst the store is swept to zero one byte per cycle, all
//   4096 bytes, and in_ready stays low until the sweep ends
// a stalled receiver holds the result register; the queue then fills and
//   in_ready falls until out_ready returns
`timescale 1ns / 1ps
`include "assert_macros.svh"
module byte_store_with_overlap_copy_core
  import bsoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [ADDR_W-1:0] target,
  input  logic [ADDR_W-1:0] source,
  input  logic [LEN_W-1:0]  count,
  input  logic [DATA_W-1:0] value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [LEN_W-1:0]  fill_count,
  output logic [DATA_W-1:0] read_byte
);

  back_status_t back_status;
  q_status_t    q_status;
  q_entry_t     push_entry;
  q_entry_t     head;
  logic         push;
  logic         pop;

  bsoc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .target      (target),
    .source      (source),
    .count       (count),
    .value       (value),
    .back_status (back_status),
    .q_status    (q_status),
    .push        (push),
    .push_entry  (push_entry)
  );

  bsoc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  bsoc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .back_status (back_status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .fill_count  (fill_count),
    .read_byte   (read_byte)
  );

  `ASSERT_IMPLIES(a_no_accept_in_clear, back_status.clearing, !in_ready, "accept during clear")
  `ASSERT_IMPLIES(a_no_push_full, q_status.full, !push, "push into full queue")
  `ASSERT_IMPLIES(a_fill_bound, out_valid, fill_count <= LEN_W'(CAPACITY), "fill beyond capacity")
  `ASSERT_IMPLIES(a_read_zero_on_fail, out_valid && !ok, read_byte == '0, "byte on failed op")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench
  import bsoc_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 432;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 40000;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] tgt;
    logic [ADDR_W-1:0] src;
    logic [LEN_W-1:0]  cnt;
    logic [DATA_W-1:0] val;
  } store_op_t;

  typedef struct packed {
    logic              ok;
    logic [LEN_W-1:0]  fill;
    logic [DATA_W-1:0] rbyte;
  } store_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        op = '0;
  logic [ADDR_W-1:0] target = '0;
  logic [ADDR_W-1:0] source = '0;
  logic [LEN_W-1:0]  count = '0;
  logic [DATA_W-1:0] value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              ok;
  logic [LEN_W-1:0]  fill_count;
  logic [DATA_W-1:0] read_byte;

  store_op_t     ops_to_send[$];
  store_result_t awaited_results[$];
  store_op_t     next_op;
  store_result_t want;

  logic [DATA_W-1:0] store_mirror [CAPACITY];
  int mirror_fill = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  byte_store_with_overlap_copy_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .target     (target),
    .source     (source),
    .count      (count),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .fill_count (fill_count),
    .read_byte  (read_byte)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic store_result_t apply_store_op(logic [1:0] o, logic [ADDR_W-1:0] t,
                                                   logic [ADDR_W-1:0] s, logic [LEN_W-1:0] n,
                                                   logic [DATA_W-1:0] v);
    store_result_t r;
    int ti;
    int si;
    int ni;
    int i;
    r = '0;
    ti = int'(t);
    si = int'(s);
    ni = int'(n);
    case (o)
      OP_WRITE: begin
        store_mirror[ti] = v;
        if (ti + 1 > mirror_fill) mirror_fill = ti + 1;
        r.ok = 1'b1;
      end
      OP_COPY: begin
        if (ni == 0) begin
          r.ok = 1'b1;
        end else if (si >= mirror_fill || (ti <= si && si + ni > mirror_fill) ||
                     ti + ni > CAPACITY) begin
          r.ok = 1'b0;
        end else begin
          // forward byte walk, so overlapping runs repeat
          for (i = 0; i < ni; i++) store_mirror[ti + i] = store_mirror[si + i];
          if (ti + ni > mirror_fill) mirror_fill = ti + ni;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (ti < mirror_fill) begin
          r.ok = 1'b1;
          r.rbyte = store_mirror[ti];
        end
      end
      default: begin
        r.ok = 1'b0;
      end
    endcase
    r.fill = LEN_W'(mirror_fill);
    return r;
  endfunction

  task automatic queue_op(logic [1:0] o, int t, int s, int n, int v);
    store_op_t item;
    item.op = o;
    item.tgt = ADDR_W'(t);
    item.src = ADDR_W'(s);
    item.cnt = LEN_W'(n);
    item.val = DATA_W'(v);
    ops_to_send.push_back(item);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_store_op(op, target, source, count, value));
      end
      if (!in_valid || in_ready) begin
        if (ops_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_op = ops_to_send.pop_front();
          op <= next_op.op;
          target <= next_op.tgt;
          source <= next_op.src;
          count <= next_op.cnt;
          value <= next_op.val;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with nothing pending");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (ok !== want.ok) begin
            $error("ok mismatch: expected %0d actual %0d", want.ok, ok);
            fail_count++;
          end
          if (fill_count !== want.fill) begin
            $error("fill_count mismatch: expected %0d actual %0d", want.fill, fill_count);
            fail_count++;
          end
          if (read_byte !== want.rbyte) begin
            $error("read_byte mismatch: expected %0h actual %0h", want.rbyte, read_byte);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int k;
    int kind;
    int fill;
    int t;
    int s;
    int n;
    int v;
    logic [1:0] o;

    foreach (store_mirror[i]) store_mirror[i] = '0;

    // empty store, then a short tail and overlapping runs
    queue_op(OP_READ, 0, 0, 0, 0);
    queue_op(OP_COPY, 5, 7, 0, 0);
    queue_op(OP_COPY, 1, 0, 3, 0);
    queue_op(OP_WRITE, 0, 0, 0, 8'hff);
    queue_op(OP_WRITE, 5, 0, 0, 8'ha5);
    queue_op(OP_READ, 2, 0, 0, 0);
    queue_op(OP_READ, 5, 0, 0, 0);
    queue_op(OP_READ, 6, 0, 0, 0);
    queue_op(OP_COPY, 20, 4, 20, 0);
    queue_op(OP_COPY, 1, 0, 10, 0);
    queue_op(OP_COPY, 0, 4, 36, 0);
    queue_op(OP_COPY, 0, 4, 37, 0);
    queue_op(OP_COPY, 3, 3, 37, 0);
    queue_op(OP_COPY, 4090, 0, 7, 0);
    queue_op(OP_UNUSED, 4095, 4095, 4096, 8'hff);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        while (ops_to_send.size() >= 4) @(negedge clk);
        if (phase == 0 && k == 150) hold_req++;
        fill = mirror_fill;
        kind = $urandom_range(0, 99);
        o = OP_WRITE;
        t = $urandom_range(0, 4095);
        s = $urandom_range(0, 4095);
        n = $urandom_range(0, 4096);
        v = $urandom_range(0, 255);
        if (kind < 5) begin
          // noise
          o = 2'($urandom_range(0, 3));
          if (o == OP_COPY && $urandom_range(0, 3) != 0) n = $urandom_range(0, 64);
        end else if (kind < 40) begin
          o = OP_WRITE;
          if ($urandom_range(0, 49) != 0) t = $urandom_range(0, (fill + 8 > 4095) ? 4095 : fill + 8);
        end else if (kind < 75) begin
          o = OP_COPY;
          s = (fill == 0) ? 0 : $urandom_range(0, fill - 1);
          n = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 32);
          case ($urandom_range(0, 2))
            0: begin
              t = s + $urandom_range(1, 8);
              if (t > 4095) t = 4095;
            end
            1: begin
              t = $urandom_range(0, s);
              if (fill > s && $urandom_range(0, 3) != 0) n = $urandom_range(1, fill - s);
            end
            default: t = $urandom_range(0, 4095);
          endcase
        end else begin
          o = OP_READ;
          if ($urandom_range(0, 19) != 0) t = (fill > 4095) ? $urandom_range(0, 4095)
                                                             : $urandom_range(0, fill);
        end
        queue_op(o, t, s, n, v);
      end
    end

    // full store: last index, whole-store and half-store copies, last source index
    queue_op(OP_WRITE, 4095, 0, 0, 8'h5a);
    queue_op(OP_READ, 4095, 0, 0, 0);
    queue_op(OP_READ, 0, 0, 0, 0);
    queue_op(OP_COPY, 4086, 2, 10, 0);
    queue_op(OP_COPY, 0, 0, 4096, 0);
    queue_op(OP_COPY, 2048, 0, 2048, 0);
    queue_op(OP_COPY, 0, 4095, 1, 0);

    while (ops_to_send.size() != 0 || in_valid) @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
    end
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
